// ===== hdl/aes128_pkg.sv =====
// ----------------------------------------------------------------------------
// aes128_pkg
// Shared types, tables and round functions of the AES-128 block cipher core.
// ----------------------------------------------------------------------------
package aes128_pkg;

    localparam int unsigned KEY_REG_W = 64;

    // Configuration register indexes
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    localparam logic [3:0] ROUND_FIRST = 4'd1;
    localparam logic [3:0] ROUND_LAST  = 4'd10;
    localparam logic [3:0] ROUND_ZERO  = 4'd0;

    typedef struct packed {
        logic        req_type;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } aes_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       key_wr_high;
        logic       key_wr_low;
        logic       key_load;
        logic       key_step;
        logic       key_save;
        logic       start;
        logic       round_en;
        logic       last;
        logic       dec;
        logic       out_load;
        logic [3:0] rnd;
    } aes_cmd_t;

    localparam logic [2047:0] SBOX_TABLE = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX_TABLE = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX_TABLE[(255 - int'(b)) * 8 +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] b);
        return INV_SBOX_TABLE[(255 - int'(b)) * 8 +: 8];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Multiply by constants of the column mixing matrices
    function automatic logic [7:0] gmul_c(input logic [7:0] a, input logic [3:0] m);
        logic [7:0] a2;
        logic [7:0] a4;
        logic [7:0] a8;
        logic [7:0] v;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        case (m)
            4'd1:    v = a;
            4'd2:    v = a2;
            4'd3:    v = a2 ^ a;
            4'd9:    v = a8 ^ a;
            4'd11:   v = a8 ^ a2 ^ a;
            4'd13:   v = a8 ^ a4 ^ a;
            4'd14:   v = a8 ^ a4 ^ a2;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = inv ? inv_sbox(s[127 - 8 * i -: 8])
                                      : sbox(s[127 - 8 * i -: 8]);
        end
        return o;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? (r + 4 * ((c - r + 4) & 3)) : (r + 4 * ((c + r) & 3));
                o[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * src -: 8];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [3:0]   m [4];
        logic [7:0]   v;
        if (inv) begin
            m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
        end else begin
            m[0] = 4'd2;  m[1] = 4'd3;  m[2] = 4'd1;  m[3] = 4'd1;
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    v = v ^ gmul_c(s[127 - 8 * (k + 4 * c) -: 8], m[(k - r + 4) & 3]);
                end
                o[127 - 8 * (r + 4 * c) -: 8] = v;
            end
        end
        return o;
    endfunction

    function automatic logic [31:0] key_g(input logic [31:0] w, input logic [7:0] rc);
        logic [31:0] t;
        t = {w[23:0], w[31:24]};
        return {sbox(t[31:24]) ^ rc, sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
    endfunction

    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        n0 = k[127:96] ^ key_g(k[31:0], rcon(r));
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // Step back from round key r to round key r-1
    function automatic logic [127:0] key_prev(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        p3 = k[31:0] ^ k[63:32];
        p2 = k[63:32] ^ k[95:64];
        p1 = k[95:64] ^ k[127:96];
        p0 = k[127:96] ^ key_g(p3, rcon(r));
        return {p0, p1, p2, p3};
    endfunction

endpackage

// ===== hdl/aes128_datapath.sv =====
// ----------------------------------------------------------------------------
// aes128_datapath
// Key registers, round key generator, cipher state and result register.
// ----------------------------------------------------------------------------
module aes128_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  aes128_pkg::aes_cmd_t        cmd,
    input  logic [aes128_pkg::KEY_REG_W-1:0] cfg_wdata,
    input  aes128_pkg::aes_in_t         s_data,
    output aes128_pkg::aes_out_t        m_data
);

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic [127:0] key10_reg;
    logic [127:0] rkey_reg;
    logic [127:0] rkey_next;
    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [127:0] out_reg;
    logic [127:0] key0;
    logic [127:0] blk;
    logic [127:0] fwd_key;
    logic [127:0] enc_state;
    logic [127:0] dec_state;
    logic [127:0] round_out;

    assign key0 = {key_high_reg, key_low_reg};
    assign blk  = {s_data.block_high, s_data.block_low};

    assign fwd_key = aes128_pkg::key_next(rkey_reg, cmd.rnd);

    always_comb begin
        enc_state = aes128_pkg::shift_rows(aes128_pkg::sub_bytes(state_reg, 1'b0), 1'b0);
        if (!cmd.last) begin
            enc_state = aes128_pkg::mix_columns(enc_state, 1'b0);
        end
        enc_state = enc_state ^ rkey_reg;

        dec_state = aes128_pkg::sub_bytes(aes128_pkg::shift_rows(state_reg, 1'b1), 1'b1)
                    ^ rkey_reg;
        if (!cmd.last) begin
            dec_state = aes128_pkg::mix_columns(dec_state, 1'b1);
        end
        round_out = cmd.dec ? dec_state : enc_state;
    end

    always_comb begin
        state_next = state_reg;
        rkey_next  = rkey_reg;
        if (cmd.start) begin
            if (s_data.req_type == aes128_pkg::REQ_DECRYPT) begin
                state_next = blk ^ key10_reg;
                rkey_next  = aes128_pkg::key_prev(key10_reg, aes128_pkg::ROUND_LAST);
            end else begin
                state_next = blk ^ key0;
                rkey_next  = aes128_pkg::key_next(key0, aes128_pkg::ROUND_FIRST);
            end
        end else if (cmd.round_en) begin
            state_next = round_out;
            rkey_next  = cmd.dec ? aes128_pkg::key_prev(rkey_reg, cmd.rnd) : fwd_key;
        end else if (cmd.key_load) begin
            rkey_next = key0;
        end else if (cmd.key_step) begin
            rkey_next = fwd_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else begin
            if (cmd.key_wr_high) begin
                key_high_reg <= cfg_wdata;
            end
            if (cmd.key_wr_low) begin
                key_low_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        if (cmd.key_save) begin
            key10_reg <= fwd_key;
        end
        if (cmd.out_load) begin
            out_reg <= round_out;
        end
    end

    assign m_data.result_high = out_reg[127:64];
    assign m_data.result_low  = out_reg[63:0];

endmodule

// ===== hdl/aes128_ctrl.sv =====
// ----------------------------------------------------------------------------
// aes128_ctrl
// Sequencer for key expansion, cipher rounds and the result handshake.
// ----------------------------------------------------------------------------
module aes128_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    output logic                 m_valid,
    input  logic                 m_ready,
    output aes128_pkg::aes_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_KINIT,
        ST_KEXP,
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    logic       dec_reg;
    logic       dec_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       cfg_hit;

    assign cfg_hit = cfg_wr_en;
    // hold off requests at the edge of a key write
    assign s_ready = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        dec_next     = dec_reg;
        cmd.dec      = dec_reg;
        cmd.key_wr_high = cfg_wr_en && (cfg_index == aes128_pkg::REG_KEY_HIGH);
        cmd.key_wr_low  = cfg_wr_en && (cfg_index == aes128_pkg::REG_KEY_LOW);

        unique case (state_reg)
            ST_KINIT: begin
                cmd.key_load = 1'b1;
                cnt_next     = aes128_pkg::ROUND_FIRST;
                state_next   = ST_KEXP;
            end
            ST_KEXP: begin
                cmd.key_step = 1'b1;
                cmd.rnd      = cnt_reg;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == aes128_pkg::ROUND_LAST) begin
                    cmd.key_save = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    dec_next   = s_req_type;
                    cnt_next   = (s_req_type == aes128_pkg::REQ_DECRYPT) ? 4'd9
                                                                         : aes128_pkg::ROUND_FIRST;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.last = dec_reg ? (cnt_reg == aes128_pkg::ROUND_ZERO)
                                   : (cnt_reg == aes128_pkg::ROUND_LAST);
                cmd.rnd  = dec_reg ? cnt_reg : cnt_reg + 4'd1;
                // hold the final round until the result slot is free
                if (!cmd.last || !m_valid_reg || m_ready) begin
                    cmd.round_en = 1'b1;
                    cnt_next     = dec_reg ? cnt_reg - 4'd1 : cnt_reg + 4'd1;
                    if (cmd.last) begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_KINIT;
            end
        endcase

        // a new key restarts the expansion
        if (cfg_hit) begin
            state_next = ST_KINIT;
        end

        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_KINIT;
            cnt_reg     <= '0;
            dec_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dec_reg     <= dec_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_cfg_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("key write did not restart expansion");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !cfg_wr_en) |=> (state_reg == ST_RUN))
        else $error("accepted request did not start rounds");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (cnt_reg <= aes128_pkg::ROUND_LAST))
        else $error("round counter out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");

endmodule

// ===== hdl/aes128_block_cipher_top.sv =====
// The single shared round unit does the initial key addition at accept, then one
// round per cycle (the final round held while a result is untaken) with keys made
// on the fly, and it takes no new request until the final round loads the result.
// Reset and every key write run a key expansion for the last round key; no request
// is accepted during it. Key registers reset to zero.
// ----------------------------------------------------------------------------
// aes128_block_cipher_top
// AES-128 encrypt/decrypt core with a plain key write port.
// ----------------------------------------------------------------------------
module aes128_block_cipher_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [aes128_pkg::KEY_REG_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  aes128_pkg::aes_in_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output aes128_pkg::aes_out_t              m_data
);

    aes128_pkg::aes_cmd_t cmd;

    aes128_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_data.req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd)
    );

    aes128_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data)
    );

endmodule
